[hdl/pps_pkg.sv]
package pps_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 16;

    localparam int PID_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int READY_W = 5;

    // Queue slot index and fill count (the count must hold QUEUE_DEPTH itself).
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_BITS  = PID_W + 3 * TIME_BITS + PRIO_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + PID_W + 5 * TIME_BITS + PRIO_W + READY_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Request payload, last field in the lowest bits.
    typedef struct packed {
        logic [TIME_BITS-1:0] now_time;
        logic [PRIO_W-1:0]    new_priority;
        logic [TIME_BITS-1:0] new_burst;
        logic [TIME_BITS-1:0] new_arrival;
        logic [PID_W-1:0]     new_pid;
    } in_t;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic                 queue_overflow;
        logic [READY_W-1:0]   ready_count;
        logic [PRIO_W-1:0]    run_priority;
        logic [TIME_BITS-1:0] run_remaining;
        logic [TIME_BITS-1:0] run_end;
        logic [TIME_BITS-1:0] run_start;
        logic [TIME_BITS-1:0] run_total;
        logic [TIME_BITS-1:0] run_arrival;
        logic [PID_W-1:0]     run_pid;
        logic                 run_valid;
    } out_t;

    // One ready-queue slot.
    typedef struct packed {
        logic [PID_W-1:0]     pid;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] total;
        logic [TIME_BITS-1:0] remaining;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    // The running-process record.
    typedef struct packed {
        logic                 valid;
        logic [PID_W-1:0]     pid;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] total;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS-1:0] finish;
        logic [TIME_BITS-1:0] remaining;
        logic [PRIO_W-1:0]    prio;
    } run_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_issue;
        logic scan_cmp;
        logic take;
        logic shift;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic shift_more;
    } status_t;

endpackage

[hdl/pps_ctrl.sv]
module pps_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  pps_pkg::status_t status,
    output pps_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_TAKE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.need_scan ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                cmd.scan_cmp   = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.scan_cmp = 1'b1;
                state_next   = ST_TAKE;
            end
            ST_TAKE: begin
                cmd.take   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (!status.shift_more) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.publish   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[hdl/pps_dp.sv]
module pps_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pps_pkg::cmd_t                cmd,
    input  logic [pps_pkg::IN_W-1:0]     s_tdata,
    input  logic                         s_tuser,
    output pps_pkg::status_t             status,
    output logic [pps_pkg::OUT_W-1:0]    m_tdata
);

    pps_pkg::in_t    in_reg;
    logic            func_reg;
    pps_pkg::run_t   run_reg, run_next;
    logic [pps_pkg::CNT_W-1:0] used_reg, used_next;
    logic            ovf_reg;
    logic [pps_pkg::CNT_W-1:0] idx_reg;
    pps_pkg::entry_t rd_data_reg;
    logic [pps_pkg::CNT_W-1:0] rd_idx_reg;
    logic            rd_ok_reg, rd_ok_next;
    pps_pkg::entry_t best_reg;
    logic [pps_pkg::IDX_W-1:0] best_idx_reg;
    logic            best_ok_reg, best_ok_next;
    pps_pkg::out_t   out_reg;

    pps_pkg::entry_t mem [pps_pkg::QUEUE_DEPTH];

    logic [pps_pkg::TIME_BITS-1:0] elapsed;
    logic [pps_pkg::TIME_BITS-1:0] rem_left;
    logic            preempt;
    logic            full;
    logic            enqueue;
    logic            cmp_hit;
    logic            mem_we;
    logic [pps_pkg::IDX_W-1:0] mem_wa;
    pps_pkg::entry_t mem_wd;
    pps_pkg::entry_t new_entry;
    pps_pkg::entry_t old_entry;

    // Time since the running process's arrival, modulo the timestamp range.
    assign elapsed  = in_reg.now_time - run_reg.arrival;
    assign rem_left = (run_reg.remaining > elapsed) ? run_reg.remaining - elapsed : '0;
    assign preempt  = run_reg.valid && (in_reg.new_priority < run_reg.prio);
    assign full     = (used_reg == pps_pkg::CNT_W'(pps_pkg::QUEUE_DEPTH));
    assign enqueue  = cmd.exec && !func_reg && run_reg.valid && !full;
    assign cmp_hit  = rd_ok_reg && (!best_ok_reg || (rd_data_reg.prio < best_reg.prio));

    assign new_entry = '{pid: in_reg.new_pid, arrival: in_reg.new_arrival,
                         total: in_reg.new_burst, remaining: in_reg.new_burst,
                         prio: in_reg.new_priority};
    assign old_entry = '{pid: run_reg.pid, arrival: run_reg.arrival,
                         total: run_reg.total, remaining: rem_left,
                         prio: run_reg.prio};

    assign status.need_scan  = func_reg && (used_reg != '0);
    assign status.scan_last  = (idx_reg == used_reg - 1'b1);
    assign status.shift_more = (idx_reg < used_reg);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = used_reg[pps_pkg::IDX_W-1:0];
        mem_wd = preempt ? old_entry : new_entry;
        if (enqueue) begin
            mem_we = 1'b1;
        end else if (cmd.shift && rd_ok_reg) begin
            // Close the gap: the slot read last cycle moves down by one.
            mem_we = 1'b1;
            mem_wa = pps_pkg::IDX_W'(rd_idx_reg - 1'b1);
            mem_wd = rd_data_reg;
        end
    end

    always_comb begin
        run_next     = run_reg;
        used_next    = used_reg;
        rd_ok_next   = cmd.scan_issue || (cmd.shift && status.shift_more);
        best_ok_next = best_ok_reg;
        if (cmd.exec) begin
            best_ok_next = 1'b0;
            if (!func_reg) begin
                if (!run_reg.valid || preempt) begin
                    run_next = '{valid: 1'b1, pid: in_reg.new_pid,
                                 arrival: in_reg.new_arrival, total: in_reg.new_burst,
                                 start: in_reg.now_time,
                                 finish: in_reg.now_time + in_reg.new_burst,
                                 remaining: in_reg.new_burst,
                                 prio: in_reg.new_priority};
                end
                if (enqueue) begin
                    used_next = used_reg + 1'b1;
                end
            end else if (used_reg == '0) begin
                run_next = '0;
            end
        end
        if (cmd.scan_cmp && cmp_hit) begin
            best_ok_next = 1'b1;
        end
        if (cmd.take) begin
            run_next = '{valid: 1'b1, pid: best_reg.pid, arrival: best_reg.arrival,
                         total: best_reg.total, start: in_reg.now_time,
                         finish: in_reg.now_time + best_reg.remaining,
                         remaining: best_reg.remaining, prio: best_reg.prio};
        end
        if (cmd.shift && !status.shift_more) begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            used_reg    <= '0;
            rd_ok_reg   <= 1'b0;
            best_ok_reg <= 1'b0;
        end else begin
            run_reg     <= run_next;
            used_reg    <= used_next;
            rd_ok_reg   <= rd_ok_next;
            best_ok_reg <= best_ok_next;
        end
    end

    // Queue storage with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[idx_reg[pps_pkg::IDX_W-1:0]];
        rd_idx_reg  <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg   <= pps_pkg::in_t'(s_tdata[pps_pkg::IN_BITS-1:0]);
            func_reg <= s_tuser;
        end
        if (cmd.exec) begin
            ovf_reg <= !func_reg && run_reg.valid && full;
            idx_reg <= '0;
        end else if (cmd.scan_issue || (cmd.shift && status.shift_more)) begin
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.take) begin
            idx_reg <= pps_pkg::CNT_W'(best_idx_reg) + 1'b1;
        end
        if (cmd.scan_cmp && cmp_hit) begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= rd_idx_reg[pps_pkg::IDX_W-1:0];
        end
        if (cmd.publish) begin
            out_reg <= '{queue_overflow: ovf_reg,
                         ready_count: pps_pkg::READY_W'(used_reg),
                         run_priority: run_reg.prio,
                         run_remaining: run_reg.remaining,
                         run_end: run_reg.finish,
                         run_start: run_reg.start,
                         run_total: run_reg.total,
                         run_arrival: run_reg.arrival,
                         run_pid: run_reg.pid,
                         run_valid: run_reg.valid};
        end
    end

    assign m_tdata = pps_pkg::OUT_W'(out_reg);

endmodule

[hdl/priority_preemptive_scheduler.sv]
// Preemptive priority scheduler with a sixteen-entry ready queue.
// Each request on the slave stream is one scheduling event: s_tuser selects
// an arrival (0) or a completion of the running process (1), and s_tdata
// carries the arriving process and the current timestamp. Every request
// yields exactly one result on the master stream: the running-process record
// after the event, the ready-queue fill count and a flag for a dropped insert.
// An arrival runs through the execute and done states; the next request can
// be accepted at the edge at which its result can first be taken. A completion
// scans the queue one entry per cycle through its single read port to find
// the most urgent entry, then closes the gap one entry per cycle; on an empty
// queue it skips both. One request is in work at a time.
// Reset clears the running record and empties the queue; queue slots are not
// cleared, since only slots below the fill count are ever read.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and processed, and its result waits until the
// previous one has been taken.
module priority_preemptive_scheduler (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Requests.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // new_pid, new_arrival, new_burst, new_priority, now_time.
    input  logic [pps_pkg::IN_W-1:0]      s_tdata,
    // func.
    input  logic                          s_tuser,
    // Results.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // run_valid, run_pid, run_arrival, run_total, run_start, run_end,
    // run_remaining, run_priority, ready_count, queue_overflow, then zero pad.
    output logic [pps_pkg::OUT_W-1:0]     m_tdata
);

    pps_pkg::cmd_t    cmd;
    pps_pkg::status_t status;

    // The controller sequences each event; the datapath holds the records.
    pps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pps_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .status  (status),
        .m_tdata (m_tdata)
    );

endmodule

[hdl/pps_checker.sv]
module pps_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [pps_pkg::OUT_W-1:0] m_tdata
);

    pps_pkg::out_t res;

    assign res = pps_pkg::out_t'(m_tdata[pps_pkg::OUT_BITS-1:0]);

    // One request at a time: the input closes right after an acceptance.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // An idle record reads as all zeros.
    a_idle_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res.run_valid) |->
        (res.run_pid == '0 && res.run_arrival == '0 && res.run_total == '0 &&
         res.run_start == '0 && res.run_end == '0 && res.run_remaining == '0 &&
         res.run_priority == '0))
        else $error("idle result carries a nonzero record");

    // A dropped insert can only happen with the queue full.
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.queue_overflow) |->
        (res.ready_count == pps_pkg::READY_W'(pps_pkg::QUEUE_DEPTH)))
        else $error("overflow reported with room in the queue");

    // The fill count never exceeds the queue depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.ready_count <= pps_pkg::READY_W'(pps_pkg::QUEUE_DEPTH)))
        else $error("ready count beyond queue depth");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or vanished");

endmodule

bind priority_preemptive_scheduler pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
